/* rtl/cctu_pkg.sv */
// Package for the contact traction update unit: codes, states, default sizes
// and a saturation helper. No dependencies.
`default_nettype none
package cctu_pkg;

  localparam int NUM_POINTS_DEF = 1024;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int MUL_W          = 34;

  localparam logic [1:0] FUNC_COMPUTE = 2'd0;
  localparam logic [1:0] FUNC_COMMIT  = 2'd1;
  localparam logic [1:0] FUNC_RESTORE = 2'd2;

  localparam logic [1:0] REG_STIFF = 2'd0;
  localparam logic [1:0] REG_MU    = 2'd1;
  localparam logic [1:0] REG_RATIO = 2'd2;
  localparam logic [1:0] REG_CLEAR = 2'd3;

  // multiply sequence steps
  localparam logic [3:0] STEP_KS   = 4'd0;
  localparam logic [3:0] STEP_KSUM = 4'd1;
  localparam logic [3:0] STEP_KSC  = 4'd2;
  localparam logic [3:0] STEP_NORM = 4'd3;
  localparam logic [3:0] STEP_MX   = 4'd4;
  localparam logic [3:0] STEP_P0   = 4'd5;
  localparam logic [3:0] STEP_P1   = 4'd6;
  localparam logic [3:0] STEP_SQ0  = 4'd7;
  localparam logic [3:0] STEP_SQ1  = 4'd8;
  localparam logic [3:0] STEP_CMP  = 4'd9;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_INDEX = 9'b000000100,
    S_READ  = 9'b000001000,
    S_MUL   = 9'b000010000,
    S_SQRT  = 9'b000100000,
    S_DSET  = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'h7fffffff;
    else if (v < -64'sd2147483648) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/cctu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cctu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/coulomb_contact_traction_update_unit.sv */
// Top level of the penalty contact / Coulomb friction traction update unit.
// Uses cctu_pkg and cctu_ram (trial and committed slip shift stores).
`default_nettype none
// Command-style unit: an item transfers when start is high and busy is low. Busy
// stays high while the item is worked on; the single result then sits on the
// result ports with done high for exactly one cycle, the first cycle with busy
// low, and the receiver cannot stall it. A new item can transfer at the edge
// that ends the done cycle. After reset both slip stores are swept to zero, one
// entry per cycle, with busy high; APB writes are taken meanwhile. Commit,
// restore and unused func keep busy high through index, read and finish. A
// compute goes through one shared 34x34 multiplier, one product per cycle. When
// the shear trial leaves the friction cone, a bit-serial square root follows
// and, per shear component, an operand setup plus restoring divide steps. The
// index step repeats, subtracting NUM_POINTS each time, while point_index is at
// or above NUM_POINTS. Only one item is in flight, so read and write-back of a
// slip entry cannot overlap.
module coulomb_contact_traction_update_unit #(
  parameter int NUM_POINTS = cctu_pkg::NUM_POINTS_DEF,
  parameter int FRAC_BITS  = cctu_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // command channel
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         func,
  input  wire logic [9:0]         point_index,
  input  wire logic [1:0]         dims,
  input  wire logic signed [31:0] shear_jump_one,
  input  wire logic signed [31:0] shear_jump_two,
  input  wire logic signed [31:0] normal_jump,
  input  wire logic               elastic_request,
  // result channel
  output logic                    done,
  output logic signed [31:0]      shear_traction_one,
  output logic signed [31:0]      shear_traction_two,
  output logic signed [31:0]      normal_traction,
  output logic                    gap_closed,
  output logic [30:0]             diagonal_stiffness,
  // APB configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  localparam int AW    = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam int IDX_W = ((AW > 10) ? AW : 10) + 1;
  localparam int MW    = cctu_pkg::MUL_W;

  // configuration registers
  logic [30:0]        kn, mu, ratio;
  logic signed [31:0] clr;

  // item registers
  cctu_pkg::state_t   state;
  logic [3:0]         step;
  logic [4:0]         cnt;
  logic [1:0]         fn, dm;
  logic [IDX_W-1:0]   idx;
  logic signed [31:0] j1, j2, jn;
  logic               elas, closed, dsel;
  logic signed [32:0] sum;
  logic [63:0]        cmt, trl;
  logic [30:0]        ksu;
  logic signed [63:0] a, b, p0, p1;
  logic signed [31:0] normal, s0, s1;
  logic [47:0]        mx;
  logic [63:0]        dp, num;
  logic [33:0]        srem;
  logic [31:0]        root, drem, quo;
  logic [AW-1:0]      clr_cnt;

  // RAM ports
  logic          t_we, c_we;
  logic [AW-1:0] waddr;
  logic [63:0]   t_wdata, c_wdata, t_rdata, c_rdata;

  // shared multiplier
  logic signed [MW-1:0]   opa, opb;
  logic signed [2*MW-1:0] prod;
  logic signed [63:0]     fsh;

  logic [31:0]        mag_s, absn;
  logic signed [31:0] sh0_new, sh1_new, s_div;
  logic [35:0]        sq_r2, sq_t;
  logic [32:0]        dv_r2;
  logic [31:0]        quo_next;

  assign pready = 1'b1;
  assign busy   = (state != cctu_pkg::S_IDLE);

  always_comb begin
    case (paddr[3:2])
      cctu_pkg::REG_STIFF: prdata = {1'b0, kn};
      cctu_pkg::REG_MU:    prdata = {1'b0, mu};
      cctu_pkg::REG_RATIO: prdata = {1'b0, ratio};
      cctu_pkg::REG_CLEAR: prdata = clr;
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kn    <= 31'(1) << FRAC_BITS;
      mu    <= '0;
      ratio <= '0;
      clr   <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        cctu_pkg::REG_STIFF: kn    <= pwdata[30:0];
        cctu_pkg::REG_MU:    mu    <= pwdata[30:0];
        cctu_pkg::REG_RATIO: ratio <= pwdata[30:0];
        cctu_pkg::REG_CLEAR: clr   <= pwdata;
        default:             ;
      endcase
    end
  end

  assign absn  = normal[31] ? 32'(-normal) : 32'(normal);
  assign mag_s = (dsel ? s1[31] : s0[31]) ? 32'(-(dsel ? s1 : s0)) : 32'(dsel ? s1 : s0);

  // operand select for the shared multiplier
  always_comb begin
    opa = '0;
    opb = '0;
    if (state == cctu_pkg::S_DSET) begin
      opa = MW'({2'b0, mag_s});
      opb = MW'({1'b0, mx[32:0]});
    end else begin
      case (step)
        cctu_pkg::STEP_KS:   begin opa = MW'({3'b0, kn});  opb = MW'({3'b0, ratio}); end
        cctu_pkg::STEP_KSUM: begin opa = MW'({3'b0, kn});  opb = MW'(sum); end
        cctu_pkg::STEP_KSC:  begin opa = MW'({3'b0, ksu}); opb = MW'(clr); end
        cctu_pkg::STEP_NORM: begin opa = MW'({3'b0, ksu}); opb = MW'(jn); end
        cctu_pkg::STEP_MX:   begin opa = MW'({2'b0, absn}); opb = MW'({3'b0, mu}); end
        cctu_pkg::STEP_P0:   begin opa = MW'({3'b0, kn});  opb = MW'(j1); end
        cctu_pkg::STEP_P1:   begin opa = MW'({3'b0, kn});  opb = MW'(j2); end
        cctu_pkg::STEP_SQ0:  begin opa = MW'(s0); opb = MW'(s0); end
        cctu_pkg::STEP_SQ1:  begin opa = MW'(s1); opb = MW'(s1); end
        cctu_pkg::STEP_CMP:  begin
          opa = MW'({1'b0, mx[32:0]});
          opb = MW'({1'b0, mx[32:0]});
        end
        default: ;
      endcase
    end
  end

  assign prod = opa * opb;
  assign fsh  = 64'(prod >>> FRAC_BITS);   // floor of the scaled product

  // sqrt and divide step logic
  assign sq_r2    = {srem, dp[63:62]};
  assign sq_t     = {2'b0, root, 2'b01};
  assign dv_r2    = {drem, num[63]};
  assign quo_next = {quo[30:0], (dv_r2 >= {1'b0, root})};
  assign s_div    = (dsel ? s1[31] : s0[31]) ? -$signed(quo_next) : $signed(quo_next);

  assign sh0_new = cctu_pkg::sat32(p0 - 64'(s0));
  assign sh1_new = (dm == 2'd3) ? cctu_pkg::sat32(p1 - 64'(s1)) : $signed(cmt[63:32]);

  // store write port
  always_comb begin
    t_we    = 1'b0;
    c_we    = 1'b0;
    waddr   = idx[AW-1:0];
    t_wdata = cmt;
    c_wdata = trl;
    if (state == cctu_pkg::S_CLEAR) begin
      t_we    = 1'b1;
      c_we    = 1'b1;
      waddr   = clr_cnt;
      t_wdata = '0;
      c_wdata = '0;
    end else if (state == cctu_pkg::S_FIN) begin
      case (fn)
        cctu_pkg::FUNC_COMPUTE: begin
          t_we = 1'b1;
          if (dm >= 2'd2) t_wdata = {sh1_new, sh0_new};
        end
        cctu_pkg::FUNC_COMMIT:  c_we = 1'b1;
        cctu_pkg::FUNC_RESTORE: t_we = 1'b1;
        default: ;
      endcase
    end
  end

  cctu_ram #(.WIDTH(64), .DEPTH(NUM_POINTS), .AW(AW)) u_trial (
    .clk(clk), .we(t_we), .waddr(waddr), .wdata(t_wdata),
    .raddr(idx[AW-1:0]), .rdata(t_rdata)
  );

  cctu_ram #(.WIDTH(64), .DEPTH(NUM_POINTS), .AW(AW)) u_commit (
    .clk(clk), .we(c_we), .waddr(waddr), .wdata(c_wdata),
    .raddr(idx[AW-1:0]), .rdata(c_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= cctu_pkg::S_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        cctu_pkg::S_CLEAR: begin
          if (clr_cnt == AW'(NUM_POINTS - 1)) state <= cctu_pkg::S_IDLE;
          else clr_cnt <= clr_cnt + 1'b1;
        end
        cctu_pkg::S_IDLE: begin
          if (start) begin
            fn    <= func;
            dm    <= dims;
            idx   <= IDX_W'(point_index);
            j1    <= shear_jump_one;
            j2    <= shear_jump_two;
            jn    <= normal_jump;
            elas  <= elastic_request;
            state <= cctu_pkg::S_INDEX;
          end
        end
        cctu_pkg::S_INDEX: begin
          // point index modulo the store depth, read issued once in range
          if (idx >= IDX_W'(NUM_POINTS)) idx <= idx - IDX_W'(NUM_POINTS);
          else state <= cctu_pkg::S_READ;
        end
        cctu_pkg::S_READ: begin
          cmt    <= c_rdata;
          trl    <= t_rdata;
          sum    <= 33'(jn) + 33'(clr);
          closed <= (33'(jn) + 33'(clr)) <= 33'sd0;
          s0     <= '0;
          s1     <= '0;
          step   <= cctu_pkg::STEP_KS;
          state  <= (fn == cctu_pkg::FUNC_COMPUTE) ? cctu_pkg::S_MUL : cctu_pkg::S_FIN;
        end
        cctu_pkg::S_MUL: begin
          step <= step + 1'b1;
          case (step)
            cctu_pkg::STEP_KS: begin
              if (prod[2*MW-1:FRAC_BITS] > (2*MW-FRAC_BITS)'(31'h7fffffff)) ksu <= '1;
              else ksu <= prod[FRAC_BITS+30:FRAC_BITS];
            end
            cctu_pkg::STEP_KSUM: a <= fsh;
            cctu_pkg::STEP_KSC:  b <= fsh;
            cctu_pkg::STEP_NORM: normal <= closed ? cctu_pkg::sat32(a - b) : cctu_pkg::sat32(fsh);
            cctu_pkg::STEP_MX:   mx <= closed ? 48'(fsh) : '0;
            cctu_pkg::STEP_P0: begin
              p0 <= fsh;
              if (dm < 2'd2) state <= cctu_pkg::S_FIN;
            end
            cctu_pkg::STEP_P1: begin
              p1 <= fsh;
              s0 <= cctu_pkg::sat32(p0 - 64'($signed(cmt[31:0])));
            end
            cctu_pkg::STEP_SQ0: begin
              dp <= prod[63:0];
              s1 <= (dm == 2'd3) ? cctu_pkg::sat32(p1 - 64'($signed(cmt[63:32]))) : '0;
            end
            cctu_pkg::STEP_SQ1: if (dm == 2'd3) dp <= dp + prod[63:0];
            cctu_pkg::STEP_CMP: begin
              // outside the cone when dp > mx^2 and mx fits 32 bits
              srem  <= '0;
              root  <= '0;
              cnt   <= '1;
              dsel  <= 1'b0;
              state <= ((mx[47:32] == '0) && (dp > prod[63:0])) ?
                       cctu_pkg::S_SQRT : cctu_pkg::S_FIN;
            end
            default: state <= cctu_pkg::S_FIN;
          endcase
        end
        cctu_pkg::S_SQRT: begin
          // two radicand bits per cycle, one root bit
          dp <= {dp[61:0], 2'b00};
          if (sq_r2 >= sq_t) begin
            srem <= 34'(sq_r2 - sq_t);
            root <= {root[30:0], 1'b1};
          end else begin
            srem <= 34'(sq_r2);
            root <= {root[30:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == '0) state <= cctu_pkg::S_DSET;
        end
        cctu_pkg::S_DSET: begin
          drem  <= prod[63:32];
          num   <= {prod[31:0], 32'b0};
          quo   <= '0;
          cnt   <= '1;
          state <= cctu_pkg::S_DIV;
        end
        cctu_pkg::S_DIV: begin
          num <= {num[62:0], 1'b0};
          if (dv_r2 >= {1'b0, root}) begin
            drem <= 32'(dv_r2 - {1'b0, root});
          end else begin
            drem <= dv_r2[31:0];
          end
          quo <= quo_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            // scaled component back with its sign; second shear component next with dims 3
            if (!dsel) s0 <= s_div;
            else       s1 <= s_div;
            if (!dsel && dm == 2'd3) begin
              dsel  <= 1'b1;
              state <= cctu_pkg::S_DSET;
            end else begin
              state <= cctu_pkg::S_FIN;
            end
          end
        end
        cctu_pkg::S_FIN: begin
          state <= cctu_pkg::S_IDLE;
          done  <= 1'b1;
          if (fn == cctu_pkg::FUNC_COMPUTE) begin
            shear_traction_one <= s0;
            shear_traction_two <= s1;
            normal_traction    <= normal;
            gap_closed         <= closed;
            diagonal_stiffness <= (elas || closed) ? kn : ksu;
          end else begin
            shear_traction_one <= '0;
            shear_traction_two <= '0;
            normal_traction    <= '0;
            gap_closed         <= 1'b0;
            diagonal_stiffness <= '0;
          end
        end
        default: state <= cctu_pkg::S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while still busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == cctu_pkg::S_DIV) |-> (drem < root))
    else $error("divider remainder not below root");
  a_fin_done: assert property (@(posedge clk) disable iff (rst)
    (state == cctu_pkg::S_FIN) |=> done)
    else $error("finish step without result strobe");
`endif
endmodule
`default_nettype wire

/* tb/sv/coulomb_contact_traction_update_unit_tb.sv */
// Self-checking bench for coulomb_contact_traction_update_unit: directed and random
// commands with APB setup changes, checked against a built-in predictor.
// Depends on cctu_pkg and the unit's RTL.
module coulomb_contact_traction_update_unit_tb;

  localparam int NPTS = 1024;
  localparam int FRAC = 16;
  localparam int IDLE_LIMIT = 6000;  // covers the store sweep after reset
  localparam int DRAIN_CYCLES = 150; // longer than the slowest compute

  typedef struct {
    logic [1:0]         func;
    logic [9:0]         idx;
    logic [1:0]         dims;
    logic signed [31:0] j1;
    logic signed [31:0] j2;
    logic signed [31:0] jn;
    logic               elastic;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] t1;
    logic signed [31:0] t2;
    logic signed [31:0] tn;
    logic               closed;
    logic [30:0]        kdiag;
  } traction_t;

  // Contact law predictor plus queue of expected tractions.
  class traction_scoreboard;
    bit [63:0]   trial_shift [NPTS];
    bit [63:0]   commit_shift[NPTS];
    longint      kn, mu, ratio, clear;
    traction_t   expected_q[$];
    int          mismatches;
    int          strays;

    function new();
      foreach (trial_shift[i]) begin
        trial_shift[i]  = '0;
        commit_shift[i] = '0;
      end
      kn = 65536; mu = 0; ratio = 0; clear = 0;
      mismatches = 0; strays = 0;
    endfunction

    function void set_reg(logic [1:0] r, logic [31:0] v);
      case (r)
        cctu_pkg::REG_STIFF: kn    = longint'(v[30:0]);
        cctu_pkg::REG_MU:    mu    = longint'(v[30:0]);
        cctu_pkg::REG_RATIO: ratio = longint'(v[30:0]);
        cctu_pkg::REG_CLEAR: clear = longint'($signed(v));
        default: ;
      endcase
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned int_root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // s*radius/root, truncated toward zero
    function longint cone_scale(longint s, longint unsigned rad, longint unsigned root);
      longint unsigned mag;
      mag = (s < 0) ? longint'(-s) : s;
      mag = (mag * rad) / root;
      return (s < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // note an accepted command and queue the traction it must produce
    function void note_command(cmd_t c);
      traction_t       e;
      longint          ks, gsum, tn, sh0, sh1, p0, p1, s0, s1;
      longint unsigned ksu, rad, dp, root;
      bit              closed;
      e = '{default: '0};
      s0 = 0; s1 = 0; rad = 0;
      if (c.func == cctu_pkg::FUNC_COMMIT) begin
        commit_shift[c.idx] = trial_shift[c.idx];
      end else if (c.func == cctu_pkg::FUNC_RESTORE) begin
        trial_shift[c.idx] = commit_shift[c.idx];
      end else if (c.func == cctu_pkg::FUNC_COMPUTE) begin
        trial_shift[c.idx] = commit_shift[c.idx];
        ksu = (longint'(kn) * longint'(ratio)) >> FRAC;
        if (ksu > 64'h7fff_ffff) ksu = 64'h7fff_ffff;
        ks = longint'(ksu);
        gsum = longint'(c.jn) + clear;
        closed = (gsum <= 0);
        if (closed) begin
          tn = clip32(((kn * gsum) >>> FRAC) - ((ks * clear) >>> FRAC));
          rad = (longint'((tn < 0) ? -tn : tn) * longint'(mu)) >> FRAC;
        end else begin
          tn = clip32((ks * longint'(c.jn)) >>> FRAC);
        end
        if (c.dims >= 2) begin
          sh0 = longint'($signed(trial_shift[c.idx][31:0]));
          sh1 = longint'($signed(trial_shift[c.idx][63:32]));
          p0 = (kn * longint'(c.j1)) >>> FRAC;
          p1 = (kn * longint'(c.j2)) >>> FRAC;
          s0 = clip32(p0 - sh0);
          dp = s0 * s0;
          if (c.dims == 3) begin
            s1 = clip32(p1 - sh1);
            dp = dp + longint'(s1 * s1);
          end
          // slip: trial outside the friction cone gets pulled back onto it
          if (rad < 64'h1_0000_0000 && dp > rad * rad) begin
            root = int_root(dp);
            s0 = cone_scale(s0, rad, root);
            if (c.dims == 3) s1 = cone_scale(s1, rad, root);
          end
          sh0 = clip32(p0 - s0);
          if (c.dims == 3) sh1 = clip32(p1 - s1);
          trial_shift[c.idx] = {sh1[31:0], sh0[31:0]};
        end
        e.t1 = s0[31:0];
        e.t2 = s1[31:0];
        e.tn = tn[31:0];
        e.closed = closed;
        e.kdiag = (c.elastic || closed) ? kn[30:0] : ksu[30:0];
      end
      expected_q.push_back(e);
    endfunction

    function void check_traction(traction_t a);
      traction_t e;
      if (expected_q.size() == 0) begin
        strays++;
        $display("unexpected result: t1=%h t2=%h tn=%h", a.t1, a.t2, a.tn);
        return;
      end
      e = expected_q.pop_front();
      if (a !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp t1=%h t2=%h tn=%h gc=%b k=%h ",
                    "act t1=%h t2=%h tn=%h gc=%b k=%h"},
                   e.t1, e.t2, e.tn, e.closed, e.kdiag, a.t1, a.t2, a.tn, a.closed, a.kdiag);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         func = cctu_pkg::FUNC_COMPUTE;
  logic [9:0]         point_index = '0;
  logic [1:0]         dims = 2'd1;
  logic signed [31:0] shear_jump_one = '0;
  logic signed [31:0] shear_jump_two = '0;
  logic signed [31:0] normal_jump = '0;
  logic               elastic_request = 1'b0;
  logic               done;
  logic signed [31:0] shear_traction_one, shear_traction_two, normal_traction;
  logic               gap_closed;
  logic [30:0]        diagonal_stiffness;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  traction_scoreboard sb = new();
  int                 stall_cycles = 0;
  int                 point_pool[8];

  always #5 clk = ~clk;

  coulomb_contact_traction_update_unit dut (
    .clk, .rst, .start, .busy, .func, .point_index, .dims,
    .shear_jump_one, .shear_jump_two, .normal_jump, .elastic_request,
    .done, .shear_traction_one, .shear_traction_two, .normal_traction,
    .gap_closed, .diagonal_stiffness,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // result monitor: a result is only valid for the one cycle done is high
  always @(posedge clk) begin
    if (!rst && done)
      sb.check_traction('{shear_traction_one, shear_traction_two, normal_traction,
                          gap_closed, diagonal_stiffness});
  end

  // watchdog: any cycle without a transfer on either side counts toward the limit
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic apb_write(logic [1:0] r, logic [31:0] v);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {r, 2'b00}; pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    sb.set_reg(r, v);
  endtask

  task automatic set_contact_law(logic [31:0] k, logic [31:0] m, logic [31:0] q,
                                 logic [31:0] c);
    apb_write(cctu_pkg::REG_STIFF, k);
    apb_write(cctu_pkg::REG_MU, m);
    apb_write(cctu_pkg::REG_RATIO, q);
    apb_write(cctu_pkg::REG_CLEAR, c);
  endtask

  // start stays high from one command to the next when no gap is wanted
  task automatic issue(cmd_t c);
    @(negedge clk);
    func = c.func; point_index = c.idx; dims = c.dims;
    shear_jump_one = c.j1; shear_jump_two = c.j2; normal_jump = c.jn;
    elastic_request = c.elastic;
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_command(c);
  endtask

  task automatic hold_off(int n);
    if (n > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) hold_off(0);
    else if (r < 95) hold_off($urandom_range(1, 6));
    else hold_off($urandom_range(20, 150));
  endtask

  // wait for every queued result, then let a slow compute finish
  task automatic drain();
    hold_off(1);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_jump();
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: return 32'sh7fffffff;
      3: return 32'sh80000000;
      4: return '0;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic cmd_t make_cmd(logic [1:0] f, int p);
    cmd_t c;
    c.func = f;
    c.idx = p[9:0];
    c.dims = 2'($urandom_range(1, 3));
    c.j1 = pick_jump();
    c.j2 = pick_jump();
    c.jn = pick_jump();
    c.elastic = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // a load step on one point: computes, then usually commit, sometimes restore; now and then one random command instead
  task automatic load_step(int p, inout int count);
    int n;
    if ($urandom_range(0, 9) == 0) begin
      issue(make_cmd(2'($urandom_range(0, 2)), p));
      random_gap();
      count++;
      return;
    end
    n = $urandom_range(1, 3);
    repeat (n) begin
      issue(make_cmd(cctu_pkg::FUNC_COMPUTE, p));
      random_gap();
      count++;
    end
    if ($urandom_range(0, 9) < 6) begin
      issue(make_cmd(cctu_pkg::FUNC_COMMIT, p));
      random_gap();
      count++;
    end else if ($urandom_range(0, 1) == 1) begin
      issue(make_cmd(cctu_pkg::FUNC_RESTORE, p));
      random_gap();
      count++;
    end
  endtask

  task automatic directed_items();
    issue('{cctu_pkg::FUNC_COMPUTE, 10'd0, 2'd1,
            32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1'b0});
    issue('{cctu_pkg::FUNC_COMPUTE, 10'd1023, 2'd3,
            32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0});
    issue('{cctu_pkg::FUNC_COMPUTE, 10'd1023, 2'd3,
            32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1'b1});
    issue('{cctu_pkg::FUNC_COMMIT, 10'd1023, 2'd1, 32'sh0, 32'sh0, 32'sh0, 1'b0});
    issue('{cctu_pkg::FUNC_COMPUTE, 10'd5, 2'd2,
            32'sh0001_0000, 32'sh0, -32'sh0001_0000, 1'b0});
    issue('{cctu_pkg::FUNC_RESTORE, 10'd1023, 2'd1, 32'sh0, 32'sh0, 32'sh0, 1'b0});
    issue('{cctu_pkg::FUNC_COMPUTE, 10'd1023, 2'd3, 32'sh0, 32'sh0, 32'sh0, 1'b1});
    drain();
    // friction on: stick inside the cone, slip outside, open gap with soft normal
    set_contact_law(32'h0001_0000, 32'h0000_8000, 32'h0000_1999, 32'h0000_0000);
    issue('{cctu_pkg::FUNC_COMPUTE, 10'd7, 2'd3,
            32'sh0000_1000, 32'sh0000_0800, -32'sh0004_0000, 1'b0});
    issue('{cctu_pkg::FUNC_COMPUTE, 10'd7, 2'd3,
            32'sh0008_0000, -32'sh0006_0000, -32'sh0001_0000, 1'b0});
    issue('{cctu_pkg::FUNC_COMMIT, 10'd7, 2'd3, 32'sh0, 32'sh0, 32'sh0, 1'b0});
    issue('{cctu_pkg::FUNC_COMPUTE, 10'd7, 2'd2,
            32'sh0010_0000, 32'sh0, -32'sh0002_0000, 1'b0});
    issue('{cctu_pkg::FUNC_COMPUTE, 10'd7, 2'd3,
            32'sh0001_0000, 32'sh0001_0000, 32'sh0003_0000, 1'b0});
    issue('{cctu_pkg::FUNC_COMPUTE, 10'd7, 2'd3,
            32'sh0001_0000, 32'sh0001_0000, 32'sh0003_0000, 1'b1});
    issue('{cctu_pkg::FUNC_RESTORE, 10'd7, 2'd1, 32'sh0, 32'sh0, 32'sh0, 1'b0});
    issue('{cctu_pkg::FUNC_COMPUTE, 10'd7, 2'd1, 32'sh0001_0000, 32'sh0, 32'sh0, 1'b0});
    drain();
  endtask

  initial begin
    logic [31:0] law[5][4];
    int          count, target, p;
    // kn, mu, open ratio, clearance per phase; extremes on both ends included
    law[0] = '{32'h0001_0000, 32'h0000_4000, 32'h0000_8000, 32'h0000_0000};
    law[1] = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    law[2] = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000};
    law[3] = '{32'h0002_0000, 32'h0001_0000, 32'h0000_0001, 32'hffff_0000};
    law[4] = '{$urandom, $urandom, $urandom, $urandom};
    repeat (7) @(negedge clk);
    rst = 1'b0;
    directed_items();
    foreach (point_pool[i]) point_pool[i] = $urandom_range(0, NPTS - 1);
    for (int ph = 0; ph < 5; ph++) begin
      set_contact_law(law[ph][0], law[ph][1], law[ph][2], law[ph][3]);
      count = 0;
      target = 360;
      while (count < target) begin
        // most steps revisit a few points so slip history builds up
        p = ($urandom_range(0, 4) == 0) ? $urandom_range(0, NPTS - 1)
                                        : point_pool[$urandom_range(0, 7)];
        load_step(p, count);
        if (ph == 2 && count > 150 && count < 156) begin
          // sender holds until everything in flight has come back
          hold_off(1);
          while (sb.expected_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
    if (sb.mismatches == 0 && sb.strays == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/cctu_pkg.sv
rtl/cctu_ram.sv
rtl/coulomb_contact_traction_update_unit.sv
tb/sv/coulomb_contact_traction_update_unit_tb.sv
